>>> rtl/vmes_pkg.sv
// Package for the von Mises equivalent block: widths, kind codes, controller
// states and the command and status structs between controller and datapath.
// No dependencies.
package vmes_pkg;

  localparam int CompBits  = 24;               // component width
  localparam int ValBits   = 25;               // equivalent value width
  localparam int SumBits   = 45;               // running sum width
  localparam int CntBits   = 21;               // running count width
  localparam int KindCnt   = 3;                // kinds with statistics
  localparam int KindBits  = 2;
  localparam int ProdBits  = 2 * CompBits;     // one square
  localparam int NdBits    = ProdBits + 2;     // sum of three squares
  localparam int ShBits    = ProdBits;         // sum of three shear squares
  localparam int RadBits   = 2 * ValBits;      // square root input
  localparam int RemBits   = ValBits + 1;      // square root remainder
  localparam int HiBits    = SumBits - ValBits; // sum bits above the quotient
  localparam int RootSteps = ValBits;          // one result bit per step
  localparam int DivSteps  = ValBits;
  localparam int StepBits  = $clog2(RootSteps);
  localparam int SqOpsTensor = 6;
  localparam int SqOpsDisp   = 3;
  localparam int DrainCycles = 2;              // operand and product stages

  localparam logic [KindBits-1:0] KindStress = 2'd0;
  localparam logic [KindBits-1:0] KindStrain = 2'd1;
  localparam logic [KindBits-1:0] KindDisp   = 2'd2;
  localparam logic [KindBits-1:0] KindNone   = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQR,
    ST_DRAIN,
    ST_RINIT,
    ST_ROOT,
    ST_UPDATE,
    ST_DINIT,
    ST_DIVIDE,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic       load;
    logic       sq_issue;
    logic [2:0] sq_idx;
    logic       root_init;
    logic       root_step;
    logic       update;
    logic       div_init;
    logic       div_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic unused;
    logic disp;
    logic last;
  } status_t;

endpackage

>>> rtl/von_mises_equivalent_with_stats.sv
// Von Mises equivalent of a stress or strain tensor, or magnitude of a
// displacement, with per-kind set minimum, maximum and truncated mean.
// Depends on vmes_pkg, vmes_ctrl and vmes_dp.
//
// One item at a time: a new item is accepted only once the last one is in
// the output register. A tensor makes six passes through the shared squarer,
// a displacement three; then comes the 25-step bit-serial square root and,
// for an item with last_of_set set, the 25-step serial divider for the mean.
// An item of the unused kind skips all of these. A finished result sits in
// the output register while the next item is accepted; the block holds a
// result only when an earlier one has not yet been taken.
module von_mises_equivalent_with_stats
  import vmes_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [KindBits-1:0]        in_action,
  input  logic signed [CompBits-1:0] in_normal_x,
  input  logic signed [CompBits-1:0] in_normal_y,
  input  logic signed [CompBits-1:0] in_normal_z,
  input  logic signed [CompBits-1:0] in_shear_xy,
  input  logic signed [CompBits-1:0] in_shear_yz,
  input  logic signed [CompBits-1:0] in_shear_xz,
  input  logic                       in_last_of_set,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [ValBits-1:0]         out_equivalent_value,
  output logic                       out_stats_valid,
  output logic [ValBits-1:0]         out_set_minimum,
  output logic [ValBits-1:0]         out_set_maximum,
  output logic [ValBits-1:0]         out_set_mean
);

  cmd_t    cmd;
  status_t status;

  vmes_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  vmes_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .in_action            (in_action),
    .in_normal_x          (in_normal_x),
    .in_normal_y          (in_normal_y),
    .in_normal_z          (in_normal_z),
    .in_shear_xy          (in_shear_xy),
    .in_shear_yz          (in_shear_yz),
    .in_shear_xz          (in_shear_xz),
    .in_last_of_set       (in_last_of_set),
    .out_equivalent_value (out_equivalent_value),
    .out_stats_valid      (out_stats_valid),
    .out_set_minimum      (out_set_minimum),
    .out_set_maximum      (out_set_maximum),
    .out_set_mean         (out_set_mean)
  );

  // an accepted item keeps the input side busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted again right after an item");

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stats_valid |-> out_set_minimum <= out_set_maximum)
    else $error("set minimum above set maximum");

  a_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stats_valid |->
      out_set_minimum == '0 && out_set_maximum == '0 && out_set_mean == '0)
    else $error("set fields not zero without statistics");

endmodule

>>> rtl/vmes_ctrl.sv
// Controller for the von Mises equivalent block: sequences squaring, square
// root, statistics update, mean division and output hand-off.
// Depends on vmes_pkg.
module vmes_ctrl
  import vmes_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  status_t status,
  output cmd_t    cmd
);

  state_t                state_r, state_nxt;
  logic [StepBits-1:0]   step_r, step_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [StepBits-1:0]   sq_last;

  assign sq_last   = status.disp ? StepBits'(SqOpsDisp - 1) : StepBits'(SqOpsTensor - 1);
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    case (state_r)
      ST_IDLE: begin
        step_nxt = '0;
        if (in_valid) state_nxt = ST_SQR;
      end
      ST_SQR: begin
        if (status.unused) begin
          state_nxt = ST_FINISH;
        end else if (step_r == sq_last) begin
          state_nxt = ST_DRAIN;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (step_r == StepBits'(DrainCycles - 1)) begin
          state_nxt = ST_RINIT;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_RINIT: begin
        state_nxt = ST_ROOT;
        step_nxt  = '0;
      end
      ST_ROOT: begin
        if (step_r == StepBits'(RootSteps - 1)) begin
          state_nxt = ST_UPDATE;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_UPDATE: begin
        state_nxt = status.last ? ST_DINIT : ST_FINISH;
      end
      ST_DINIT: begin
        state_nxt = ST_DIVIDE;
        step_nxt  = '0;
      end
      ST_DIVIDE: begin
        if (step_r == StepBits'(DivSteps - 1)) begin
          state_nxt = ST_FINISH;
          step_nxt  = '0;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
        step_nxt  = '0;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE:   cmd.load = in_valid;
      ST_SQR: begin
        cmd.sq_issue = !status.unused;
        cmd.sq_idx   = step_r[2:0];
      end
      ST_DRAIN:  cmd = '0;
      ST_RINIT:  cmd.root_init = 1'b1;
      ST_ROOT:   cmd.root_step = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_DINIT:  cmd.div_init = 1'b1;
      ST_DIVIDE: cmd.div_step = 1'b1;
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default:   cmd = '0;
    endcase
  end

endmodule

>>> rtl/vmes_dp.sv
// Datapath for the von Mises equivalent block: shared squarer with
// accumulators, bit-serial square root, per-kind statistics, serial divider
// for the mean and the output register. Depends on vmes_pkg.
module vmes_dp
  import vmes_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  cmd_t                       cmd,
  output status_t                    status,
  input  logic [KindBits-1:0]        in_action,
  input  logic signed [CompBits-1:0] in_normal_x,
  input  logic signed [CompBits-1:0] in_normal_y,
  input  logic signed [CompBits-1:0] in_normal_z,
  input  logic signed [CompBits-1:0] in_shear_xy,
  input  logic signed [CompBits-1:0] in_shear_yz,
  input  logic signed [CompBits-1:0] in_shear_xz,
  input  logic                       in_last_of_set,
  output logic [ValBits-1:0]         out_equivalent_value,
  output logic                       out_stats_valid,
  output logic [ValBits-1:0]         out_set_minimum,
  output logic [ValBits-1:0]         out_set_maximum,
  output logic [ValBits-1:0]         out_set_mean
);

  // captured item
  logic [KindBits-1:0]        kind_r;
  logic                       last_r;
  logic signed [CompBits-1:0] nx_r, ny_r, nz_r, sxy_r, syz_r, sxz_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_action;
      last_r <= in_last_of_set;
      nx_r   <= in_normal_x;
      ny_r   <= in_normal_y;
      nz_r   <= in_normal_z;
      sxy_r  <= in_shear_xy;
      syz_r  <= in_shear_yz;
      sxz_r  <= in_shear_xz;
    end
  end

  assign status.unused = (kind_r == KindNone);
  assign status.disp   = (kind_r == KindDisp);
  assign status.last   = last_r;

  // squarer operand: magnitude of a difference or of a single component
  logic signed [CompBits-1:0] opa, opb;
  logic signed [CompBits:0]   diff, mag;
  logic                       op_shear;

  always_comb begin
    opa      = nx_r;
    opb      = '0;
    op_shear = 1'b0;
    if (status.disp) begin
      case (cmd.sq_idx)
        3'd0:    opa = nx_r;
        3'd1:    opa = ny_r;
        3'd2:    opa = nz_r;
        default: opa = nx_r;
      endcase
    end else begin
      case (cmd.sq_idx)
        3'd0: begin opa = nx_r;  opb = ny_r; end
        3'd1: begin opa = ny_r;  opb = nz_r; end
        3'd2: begin opa = nz_r;  opb = nx_r; end
        3'd3: begin opa = sxy_r; op_shear = 1'b1; end
        3'd4: begin opa = syz_r; op_shear = 1'b1; end
        3'd5: begin opa = sxz_r; op_shear = 1'b1; end
        default: begin opa = nx_r; opb = ny_r; end
      endcase
    end
    diff = {opa[CompBits-1], opa} - {opb[CompBits-1], opb};
    mag  = diff[CompBits] ? -diff : diff;
  end

  logic [CompBits-1:0] op_r;
  logic                op_v_r, op_sh_r;
  logic [ProdBits-1:0] prod_r;
  logic                prod_v_r, prod_sh_r;
  logic [NdBits-1:0]   nd_r;
  logic [ShBits-1:0]   sh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
    end else begin
      op_v_r   <= cmd.sq_issue;
      prod_v_r <= op_v_r;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= mag[CompBits-1:0];
    op_sh_r   <= op_shear;
    prod_r    <= {{CompBits{1'b0}}, op_r} * {{CompBits{1'b0}}, op_r};
    prod_sh_r <= op_sh_r;
    if (cmd.load) begin
      nd_r <= '0;
      sh_r <= '0;
    end else if (prod_v_r) begin
      if (prod_sh_r) sh_r <= sh_r + prod_r;
      else           nd_r <= nd_r + {{(NdBits-ProdBits){1'b0}}, prod_r};
    end
  end

  // square root, one result bit per step
  logic [RadBits-1:0] rad_r, rad_nxt;
  logic [RemBits-1:0] rem_r;
  logic [ValBits-1:0] root_r;
  logic [RadBits-1:0] sh3;
  logic [RemBits+1:0] rem_sh, trial, rem_dif;
  logic               root_ge;

  always_comb begin
    sh3     = {2'b00, sh_r} + {1'b0, sh_r, 1'b0};
    rad_nxt = status.disp ? nd_r : ({1'b0, nd_r[NdBits-1:1]} + sh3);
    rem_sh  = {rem_r, rad_r[RadBits-1 -: 2]};
    trial   = {1'b0, root_r, 2'b01};
    root_ge = (rem_sh >= trial);
    rem_dif = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (cmd.root_init) begin
      rad_r  <= rad_nxt;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.root_step) begin
      rad_r  <= {rad_r[RadBits-3:0], 2'b00};
      rem_r  <= root_ge ? rem_dif[RemBits-1:0] : rem_sh[RemBits-1:0];
      root_r <= {root_r[ValBits-2:0], root_ge};
    end
  end

  // per-kind statistics
  logic [ValBits-1:0] kmin_r [KindCnt];
  logic [ValBits-1:0] kmax_r [KindCnt];
  logic [SumBits-1:0] ksum_r [KindCnt];
  logic [CntBits-1:0] kcnt_r [KindCnt];

  logic [ValBits-1:0] min_nxt, max_nxt;
  logic [SumBits-1:0] sum_nxt;
  logic [SumBits:0]   sum_add;
  logic [CntBits-1:0] cnt_nxt;

  always_comb begin
    min_nxt = (root_r < kmin_r[kind_r]) ? root_r : kmin_r[kind_r];
    max_nxt = (root_r > kmax_r[kind_r]) ? root_r : kmax_r[kind_r];
    sum_add = {1'b0, ksum_r[kind_r]} + {{(SumBits+1-ValBits){1'b0}}, root_r};
    if (kcnt_r[kind_r] == '1) begin
      cnt_nxt = kcnt_r[kind_r];
      sum_nxt = ksum_r[kind_r];
    end else begin
      cnt_nxt = kcnt_r[kind_r] + 1'b1;
      sum_nxt = sum_add[SumBits] ? '1 : sum_add[SumBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < KindCnt; k++) begin
        kmin_r[k] <= '1;
        kmax_r[k] <= '0;
        ksum_r[k] <= '0;
        kcnt_r[k] <= '0;
      end
    end else if (cmd.update) begin
      if (last_r) begin
        kmin_r[kind_r] <= '1;
        kmax_r[kind_r] <= '0;
        ksum_r[kind_r] <= '0;
        kcnt_r[kind_r] <= '0;
      end else begin
        kmin_r[kind_r] <= min_nxt;
        kmax_r[kind_r] <= max_nxt;
        ksum_r[kind_r] <= sum_nxt;
        kcnt_r[kind_r] <= cnt_nxt;
      end
    end
  end

  // result of the item in progress
  logic [ValBits-1:0] res_val_r, res_min_r, res_max_r;
  logic               res_stv_r;
  logic [SumBits-1:0] dsum_r;
  logic [CntBits-1:0] dcnt_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_val_r <= '0;
      res_stv_r <= 1'b0;
      res_min_r <= '0;
      res_max_r <= '0;
    end else if (cmd.update) begin
      res_val_r <= root_r;
      if (last_r) begin
        res_stv_r <= 1'b1;
        res_min_r <= min_nxt;
        res_max_r <= max_nxt;
        dsum_r    <= sum_nxt;
        dcnt_r    <= cnt_nxt;
      end
    end
  end

  // mean: quotient saturates when the upper sum bits already reach the count
  logic [CntBits-1:0] drem_r;
  logic [ValBits-1:0] dq_r;
  logic               dsat_r;
  logic [CntBits:0]   drem_sh, drem_dif;
  logic               div_ge;

  always_comb begin
    drem_sh  = {drem_r, dq_r[ValBits-1]};
    div_ge   = (drem_sh >= {1'b0, dcnt_r});
    drem_dif = drem_sh - {1'b0, dcnt_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      drem_r <= {{(CntBits-HiBits){1'b0}}, dsum_r[SumBits-1 -: HiBits]};
      dq_r   <= dsum_r[ValBits-1:0];
      dsat_r <= ({{(CntBits-HiBits){1'b0}}, dsum_r[SumBits-1 -: HiBits]} >= dcnt_r);
    end else if (cmd.div_step) begin
      drem_r <= div_ge ? drem_dif[CntBits-1:0] : drem_sh[CntBits-1:0];
      dq_r   <= {dq_r[ValBits-2:0], div_ge};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_equivalent_value <= res_val_r;
      out_stats_valid      <= res_stv_r;
      out_set_minimum      <= res_min_r;
      out_set_maximum      <= res_max_r;
      out_set_mean         <= res_stv_r ? (dsat_r ? '1 : dq_r) : '0;
    end
  end

endmodule

>>> tb/von_mises_equivalent_with_stats_test.sv
`timescale 1ns / 1ps
// Testbench for von_mises_equivalent_with_stats: directed and random node items,
// checked against an exact predictor of the equivalent value and set statistics.
// Depends on vmes_pkg and the block's RTL.
module von_mises_equivalent_with_stats_test;
  import vmes_pkg::*;

  localparam int RandomItems = 1650;
  localparam int IdleLimit   = 2000;
  localparam int TailCycles  = 100;

  localparam logic [ValBits-1:0] ValMax = '1;
  localparam logic [SumBits-1:0] SumMax = '1;
  localparam logic [CntBits-1:0] CntMax = '1;
  localparam logic signed [CompBits-1:0] CompMax = {1'b0, {(CompBits-1){1'b1}}};
  localparam logic signed [CompBits-1:0] CompMin = {1'b1, {(CompBits-1){1'b0}}};
  localparam logic signed [CompBits-1:0] CompZero = '0;
  localparam logic signed [CompBits-1:0] CompNegOne = '1;

  typedef struct {
    logic [KindBits-1:0]        action;
    logic signed [CompBits-1:0] nx, ny, nz, sxy, syz, sxz;
    logic                       last;
    int                         gap;
  } node_t;

  typedef struct {
    logic [ValBits-1:0] value;
    logic               stats;
    logic [ValBits-1:0] lo, hi, mean;
  } result_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [KindBits-1:0]        in_action = '0;
  logic signed [CompBits-1:0] in_normal_x = '0;
  logic signed [CompBits-1:0] in_normal_y = '0;
  logic signed [CompBits-1:0] in_normal_z = '0;
  logic signed [CompBits-1:0] in_shear_xy = '0;
  logic signed [CompBits-1:0] in_shear_yz = '0;
  logic signed [CompBits-1:0] in_shear_xz = '0;
  logic                       in_last_of_set = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic [ValBits-1:0]         out_equivalent_value;
  logic                       out_stats_valid;
  logic [ValBits-1:0]         out_set_minimum;
  logic [ValBits-1:0]         out_set_maximum;
  logic [ValBits-1:0]         out_set_mean;

  von_mises_equivalent_with_stats dut (.*);

  // per-kind running statistics as the block should hold them
  logic [ValBits-1:0] run_min [KindCnt];
  logic [ValBits-1:0] run_max [KindCnt];
  logic [SumBits-1:0] run_sum [KindCnt];
  logic [CntBits-1:0] run_cnt [KindCnt];

  node_t   pending_nodes[$];
  result_t predicted_results[$];
  node_t   node_on_bus;
  int      gap_left = 0;
  int      stall_left = 0;
  int      mismatch_count = 0;
  int      results_checked = 0;
  int      stats_results = 0;
  int      kind_items [4] = '{0, 0, 0, 0};
  int      cycle_count = 0;
  int      idle_cycles = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void clear_kind(int k);
    run_min[k] = ValMax;
    run_max[k] = '0;
    run_sum[k] = '0;
    run_cnt[k] = '0;
  endfunction

  function automatic longint unsigned square(longint signed a);
    return longint'(a * a);
  endfunction

  // bit-by-bit floor square root, one result bit per pass
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  function automatic result_t von_mises_predict(node_t n);
    result_t            r;
    longint signed      x, y, z;
    longint unsigned    rad, root;
    int                 k;
    logic [SumBits:0]   wide_sum;
    logic [SumBits-1:0] quot;
    r = '{default: '0};
    if (n.action == KindNone) return r;
    k = n.action;
    x = n.nx;
    y = n.ny;
    z = n.nz;
    if (n.action == KindDisp) begin
      rad = square(x) + square(y) + square(z);
    end else begin
      rad = ((square(x - y) + square(y - z) + square(z - x)) >> 1)
          + 3 * (square(n.sxy) + square(n.syz) + square(n.sxz));
    end
    root = floor_root(rad);
    r.value = (root > ValMax) ? ValMax : root[ValBits-1:0];
    if (r.value < run_min[k]) run_min[k] = r.value;
    if (r.value > run_max[k]) run_max[k] = r.value;
    // a saturated count freezes the sum
    if (run_cnt[k] != CntMax) begin
      run_cnt[k] = run_cnt[k] + 1'b1;
      wide_sum = run_sum[k] + r.value;
      run_sum[k] = wide_sum[SumBits] ? SumMax : wide_sum[SumBits-1:0];
    end
    if (n.last) begin
      quot = run_sum[k] / run_cnt[k];
      r.stats = 1'b1;
      r.lo = run_min[k];
      r.hi = run_max[k];
      r.mean = (quot > ValMax) ? ValMax : quot[ValBits-1:0];
      clear_kind(k);
    end
    return r;
  endfunction

  function automatic logic signed [CompBits-1:0] rand_comp();
    logic [31:0] raw;
    raw = $urandom;
    case ($urandom_range(9))
      0: return CompMax;
      1: return CompMin;
      2: return CompZero;
      3, 4: return $signed(raw[CompBits-1:0]) >>> (CompBits - 9);
      default: return raw[CompBits-1:0];
    endcase
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(50, 8);
  endfunction

  task automatic queue_node(logic [KindBits-1:0] action,
                            logic signed [CompBits-1:0] x, y, z, xy, yz, xz,
                            logic last, bit quiet);
    node_t n;
    n.action = action;
    n.nx = x;
    n.ny = y;
    n.nz = z;
    n.sxy = xy;
    n.syz = yz;
    n.sxz = xz;
    n.last = last;
    n.gap = pick_gap(quiet);
    pending_nodes = {pending_nodes, n};
  endtask

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // driver: one item at a time from pending_nodes, prediction at acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_results = {predicted_results, von_mises_predict(node_on_bus)};
        kind_items[node_on_bus.action]++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_nodes.size() != 0) begin
          node_on_bus = pending_nodes.pop_front();
          gap_left = node_on_bus.gap;
          in_action <= node_on_bus.action;
          in_normal_x <= node_on_bus.nx;
          in_normal_y <= node_on_bus.ny;
          in_normal_z <= node_on_bus.nz;
          in_shear_xy <= node_on_bus.sxy;
          in_shear_yz <= node_on_bus.syz;
          in_shear_xz <= node_on_bus.sxz;
          in_last_of_set <= node_on_bus.last;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result and drives random stalls
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_checked++;
        if (predicted_results.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing predicted",
                                    out_equivalent_value));
        end else begin
          want = predicted_results.pop_front();
          if (want.stats) stats_results++;
          if (out_equivalent_value !== want.value)
            report_mismatch($sformatf("equivalent_value got %0d want %0d",
                                      out_equivalent_value, want.value));
          if (out_stats_valid !== want.stats)
            report_mismatch($sformatf("stats_valid got %0d want %0d",
                                      out_stats_valid, want.stats));
          if (out_set_minimum !== want.lo)
            report_mismatch($sformatf("set_minimum got %0d want %0d",
                                      out_set_minimum, want.lo));
          if (out_set_maximum !== want.hi)
            report_mismatch($sformatf("set_maximum got %0d want %0d",
                                      out_set_maximum, want.hi));
          if (out_set_mean !== want.mean)
            report_mismatch($sformatf("set_mean got %0d want %0d",
                                      out_set_mean, want.mean));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (cycle_count % 3000 < 600) begin
        out_stall <= 1'b0;
      end else begin
        case ($urandom_range(99))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14: begin
            stall_left = $urandom_range(2, 0);
            out_stall <= 1'b1;
          end
          15, 16: begin
            stall_left = $urandom_range(60, 10);
            out_stall <= 1'b1;
          end
          default: out_stall <= 1'b0;
        endcase
      end
    end
  end

  // watchdog on cycles with no acceptance on either side
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int  counted;
    int  k;
    int  remaining [KindCnt];
    bit  quiet;
    logic last;
    for (int i = 0; i < KindCnt; i++) begin
      clear_kind(i);
      remaining[i] = 0;
    end

    // directed: extremes, every kind, unused kind, single and multi-item sets
    queue_node(KindStress, CompZero, CompZero, CompZero, CompZero, CompZero, CompZero,
               1'b1, 1'b0);
    queue_node(KindStress, CompMax, CompMax, CompMax, CompMax, CompMax, CompMax,
               1'b0, 1'b0);
    queue_node(KindStress, CompMax, CompMin, CompZero, CompMin, CompMin, CompMin,
               1'b0, 1'b0);
    queue_node(KindStrain, CompZero, CompZero, CompZero, CompMax, CompMax, CompMax,
               1'b0, 1'b0);
    // hydrostatic tensor has zero equivalent
    queue_node(KindStress, CompMin, CompMin, CompMin, CompZero, CompZero, CompZero,
               1'b1, 1'b0);
    queue_node(KindStrain, CompMin, CompMin, CompMin, CompMin, CompMin, CompMin,
               1'b0, 1'b0);
    queue_node(KindStrain, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
               rand_comp(), rand_comp(), 1'b1, 1'b0);
    // shears are ignored for displacement
    queue_node(KindDisp, CompMax, CompMax, CompMax, CompMin, CompMin, CompMin,
               1'b0, 1'b0);
    queue_node(KindDisp, CompMin, CompMin, CompMin, CompMax, CompMax, CompMax,
               1'b0, 1'b0);
    queue_node(KindDisp, CompNegOne, CompNegOne, CompZero, CompMax, CompZero, CompMin,
               1'b1, 1'b0);
    queue_node(KindNone, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
               rand_comp(), rand_comp(), 1'b1, 1'b0);
    queue_node(KindNone, CompMax, CompMax, CompMax, CompMax, CompMax, CompMax,
               1'b0, 1'b0);
    queue_node(KindStress, CompNegOne, CompNegOne, CompNegOne, CompNegOne, CompNegOne,
               CompNegOne, 1'b1, 1'b0);
    queue_node(KindDisp, CompZero, CompZero, CompZero, CompZero, CompZero, CompZero,
               1'b1, 1'b0);
    queue_node(KindStrain, CompMax, CompMin, CompMax, CompMax, CompMax, CompMax,
               1'b1, 1'b0);

    // random: interleaved sets per kind, some unused-kind noise and broken boundaries
    counted = 0;
    while (counted < RandomItems) begin
      quiet = ((counted / 150) % 4) == 2;
      if ($urandom_range(19) == 0) begin
        queue_node(KindNone, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                   rand_comp(), rand_comp(), 1'($urandom_range(1)), quiet);
        counted++;
      end else begin
        k = $urandom_range(KindCnt - 1);
        if (remaining[k] == 0)
          remaining[k] = ($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                                  : $urandom_range(6, 1);
        remaining[k]--;
        last = (remaining[k] == 0);
        if ($urandom_range(49) == 0) begin
          last = !last;
          remaining[k] = 0;
        end
        queue_node(KindBits'(k), rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                   rand_comp(), rand_comp(), last, quiet);
        counted++;
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk); while (pending_nodes.size() != 0 || in_valid);
    do @(posedge clk); while (predicted_results.size() != 0);
    repeat (TailCycles) @(posedge clk);

    $display("items: %0d stress, %0d strain, %0d displacement, %0d unused kind",
             kind_items[KindStress], kind_items[KindStrain], kind_items[KindDisp],
             kind_items[KindNone]);
    $display("results checked: %0d, %0d carrying set statistics, %0d mismatches",
             results_checked, stats_results, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/vmes_pkg.sv
rtl/vmes_ctrl.sv
rtl/vmes_dp.sv
rtl/von_mises_equivalent_with_stats.sv
tb/von_mises_equivalent_with_stats_test.sv
